// ----- hdl/lzsd_pkg.sv -----
// Shared types and constants for the LZSS stream decoder.
`timescale 1ns / 1ps

package lzsd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_BIAS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_START  = 1'b1;

    localparam logic [2:0] LENGTH_BIAS_RESET = 3'd2;
    localparam logic [2:0] MAX_BIAS          = 3'd4;
    localparam logic [3:0] FLAG_COUNT        = 4'd8;

    localparam int OUT_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_ITEM  = 3'b010,
        PH_MATCH = 3'b100
    } phase_t;

    // One unit of work for the copy engine: a literal or a match.
    typedef struct packed {
        logic        is_lit;
        logic [7:0]  data;
        logic [11:0] pos;
        logic [4:0]  len;
    } cmd_t;

endpackage

// ----- hdl/lzss_stream_decoder_core.sv -----
// Top level of the LZSS stream decoder.
// A literal passes through the command queue, the current-command registers, the stage
// registers and the output buffer before it reaches m_tdata. The copy engine issues one
// output byte per cycle while the output buffer has room, and takes a new literal or match
// only after the last one is done. After reset the history ring is cleared one entry per
// cycle, all 2^WINDOW_BITS entries (4096 by default); s_tready stays low until it is done.
`timescale 1ns / 1ps

module lzss_stream_decoder_core
#(
    parameter int WINDOW_BITS = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lzsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lzsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] packed_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tlast
);

    logic           clearing;
    logic           q_ready;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    lzsd_pkg::cmd_t push_cmd;
    lzsd_pkg::cmd_t head_cmd;

    lzsd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .hold      (clearing),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    lzsd_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    lzsd_back #(.WINDOW_BITS(WINDOW_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ----- hdl/lzsd_front.sv -----
// Front end: parses flag, literal and match bytes into copy commands.
`timescale 1ns / 1ps

module lzsd_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lzsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lzsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    input  logic [7:0]                         in_byte,
    output logic                               in_ready,
    input  logic                               hold,
    input  logic                               q_ready,
    output logic                               q_push,
    output lzsd_pkg::cmd_t                     q_cmd
);

    lzsd_pkg::phase_t phase_reg;
    logic [7:0]       flag_bits_reg;
    logic [3:0]       flags_left_reg;
    logic [7:0]       held_reg;
    logic [2:0]       bias_reg;

    logic             accept;
    logic             flag_due;
    logic [2:0]       bias_sat;
    logic [4:0]       match_len;
    logic [3:0]       left_dec;

    assign in_ready  = !hold && q_ready;
    assign accept    = in_valid && in_ready;
    assign flag_due  = (phase_reg == lzsd_pkg::PH_FLAG) || (flags_left_reg == 4'd0);
    assign bias_sat  = (bias_reg > lzsd_pkg::MAX_BIAS) ? lzsd_pkg::MAX_BIAS : bias_reg;
    assign match_len = {1'b0, in_byte[3:0]} + 5'(bias_sat);
    assign left_dec  = flags_left_reg - 4'd1;

    always_comb
    begin
        q_push       = 1'b0;
        q_cmd.is_lit = 1'b1;
        q_cmd.data   = in_byte;
        q_cmd.pos    = {in_byte[7:4], held_reg};
        q_cmd.len    = 5'd1;
        if (accept && !flag_due)
        begin
            case (phase_reg)
                lzsd_pkg::PH_ITEM:
                begin
                    q_push = flag_bits_reg[0];
                end
                lzsd_pkg::PH_MATCH:
                begin
                    q_push       = (match_len != 5'd0);
                    q_cmd.is_lit = 1'b0;
                    q_cmd.len    = match_len;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lzsd_pkg::PH_FLAG;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            held_reg       <= '0;
            bias_reg       <= lzsd_pkg::LENGTH_BIAS_RESET;
        end
        else
        begin
            if (cfg_we && (cfg_index == lzsd_pkg::CFG_LENGTH_BIAS))
            begin
                bias_reg <= cfg_data[2:0];
            end
            if (accept)
            begin
                if (flag_due)
                begin
                    flag_bits_reg  <= in_byte;
                    flags_left_reg <= lzsd_pkg::FLAG_COUNT;
                    phase_reg      <= lzsd_pkg::PH_ITEM;
                end
                else if ((phase_reg == lzsd_pkg::PH_ITEM) && !flag_bits_reg[0])
                begin
                    held_reg  <= in_byte;
                    phase_reg <= lzsd_pkg::PH_MATCH;
                end
                else
                begin
                    flag_bits_reg  <= {1'b0, flag_bits_reg[7:1]};
                    flags_left_reg <= left_dec;
                    phase_reg      <= (left_dec == 4'd0) ? lzsd_pkg::PH_FLAG
                                                         : lzsd_pkg::PH_ITEM;
                end
            end
        end
    end

endmodule

// ----- hdl/lzsd_cmd_queue.sv -----
// Two-entry command queue between the parser and the copy engine.
`timescale 1ns / 1ps

module lzsd_cmd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lzsd_pkg::cmd_t push_cmd,
    output logic           ready,
    input  logic           pop,
    output logic           valid,
    output lzsd_pkg::cmd_t head_cmd
);

    lzsd_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign ready    = (count_reg != 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/lzsd_back.sv -----
// Copy engine: history ring, match copy loop and output buffer.
`timescale 1ns / 1ps

module lzsd_back
#(
    parameter int WINDOW_BITS = 12
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lzsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lzsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               q_valid,
    input  lzsd_pkg::cmd_t                     q_cmd,
    output logic                               q_pop,
    output logic                               clearing,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_byte,
    output logic                               out_last
);

    localparam int RING_SIZE = 1 << WINDOW_BITS;

    logic [7:0]             ring_mem [RING_SIZE];

    logic                   clearing_reg;
    logic [WINDOW_BITS-1:0] clr_addr_reg;
    logic [WINDOW_BITS-1:0] wp_reg;

    logic                   cur_active_reg;
    logic [4:0]             cur_left_reg;
    logic [WINDOW_BITS-1:0] cur_pos_reg;
    logic                   cur_is_lit_reg;
    logic [7:0]             cur_byte_reg;

    logic                   s_valid_reg;
    logic                   s_is_lit_reg;
    logic [7:0]             s_lit_reg;
    logic                   s_last_reg;
    logic [7:0]             rd_data_reg;
    logic                   byp_reg;
    logic                   byp_next;
    logic [7:0]             byp_data_reg;

    logic [7:0]             ob_byte_reg [lzsd_pkg::OUT_DEPTH];
    logic                   ob_last_reg [lzsd_pkg::OUT_DEPTH];
    logic [1:0]             ob_wr_reg;
    logic [1:0]             ob_rd_reg;
    logic [2:0]             ob_count_reg;

    logic [15:0]            cmd_pos_ext;
    logic [15:0]            start_ext;
    logic [2:0]             occupancy;
    logic                   issue;
    logic                   ob_pop;
    logic [7:0]             b_byte;

    assign clearing    = clearing_reg;
    assign cmd_pos_ext = 16'(q_cmd.pos);
    assign start_ext   = 16'(cfg_data);
    assign occupancy   = ob_count_reg + {2'b00, s_valid_reg};
    assign issue       = cur_active_reg && (occupancy < 3'(lzsd_pkg::OUT_DEPTH));
    assign q_pop       = !clearing_reg && !cur_active_reg && q_valid;
    assign byp_next    = issue && s_valid_reg && (cur_pos_reg == wp_reg);
    assign b_byte      = s_is_lit_reg ? s_lit_reg : (byp_reg ? byp_data_reg : rd_data_reg);

    assign out_valid   = (ob_count_reg != 3'd0);
    assign out_byte    = ob_byte_reg[ob_rd_reg];
    assign out_last    = ob_last_reg[ob_rd_reg];
    assign ob_pop      = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            ring_mem[clr_addr_reg] <= 8'd0;
        end
        else if (s_valid_reg)
        begin
            ring_mem[wp_reg] <= b_byte;
        end
        if (issue)
        begin
            rd_data_reg <= ring_mem[cur_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= b_byte;
        if (q_pop)
        begin
            cur_pos_reg    <= cmd_pos_ext[WINDOW_BITS-1:0];
            cur_is_lit_reg <= q_cmd.is_lit;
            cur_byte_reg   <= q_cmd.data;
        end
        else if (issue)
        begin
            cur_pos_reg <= cur_pos_reg + 1'b1;
        end
        if (issue)
        begin
            s_is_lit_reg <= cur_is_lit_reg;
            s_lit_reg    <= cur_byte_reg;
            s_last_reg   <= (cur_left_reg == 5'd1);
        end
        if (s_valid_reg)
        begin
            ob_byte_reg[ob_wr_reg] <= b_byte;
            ob_last_reg[ob_wr_reg] <= s_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            wp_reg         <= '0;
            cur_active_reg <= 1'b0;
            cur_left_reg   <= '0;
            s_valid_reg    <= 1'b0;
            byp_reg        <= 1'b0;
            ob_wr_reg      <= '0;
            ob_rd_reg      <= '0;
            ob_count_reg   <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {WINDOW_BITS{1'b1}})
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (cfg_we && (cfg_index == lzsd_pkg::CFG_RING_START))
            begin
                wp_reg <= start_ext[WINDOW_BITS-1:0];
            end
            else if (s_valid_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end

            if (q_pop)
            begin
                cur_active_reg <= 1'b1;
                cur_left_reg   <= q_cmd.len;
            end
            else if (issue)
            begin
                cur_left_reg <= cur_left_reg - 5'd1;
                if (cur_left_reg == 5'd1)
                begin
                    cur_active_reg <= 1'b0;
                end
            end

            s_valid_reg <= issue;
            byp_reg     <= byp_next;

            if (s_valid_reg)
            begin
                ob_wr_reg <= ob_wr_reg + 2'd1;
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ob_rd_reg + 2'd1;
            end
            if (s_valid_reg && !ob_pop)
            begin
                ob_count_reg <= ob_count_reg + 3'd1;
            end
            else if (ob_pop && !s_valid_reg)
            begin
                ob_count_reg <= ob_count_reg - 3'd1;
            end
        end
    end

    a_ob_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_valid_reg && !ob_pop && (ob_count_reg == 3'(lzsd_pkg::OUT_DEPTH))))
        else $error("output buffer overflow");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!cur_active_reg && !s_valid_reg))
        else $error("copy activity during ring clearing");

    a_active_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_active_reg |-> (cur_left_reg != 5'd0))
        else $error("active command with zero bytes left");

    a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && (cur_left_reg == 5'd1)) |=> !cur_active_reg)
        else $error("command did not retire after its last byte");

endmodule
